// ===== hdl/prw_pkg.sv =====
// Shared types and constants of the Prewitt edge magnitude block.
// No dependencies; every other file of the block imports this package.
package prw_pkg;

    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned CNT_W       = 11;
    localparam int unsigned DIM_W       = 12;
    localparam int unsigned MAX_DIM     = 2048;
    localparam int unsigned MIN_DIM     = 3;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [CNT_W-1:0]  coord_t;
    typedef logic [DIM_W-1:0]  dim_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Red sits in the low byte, as in the packed pixel word.
    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } pix_t;

    // px[x][y]: x = left, centre, right; y = top, middle, bottom.
    typedef struct packed {
        pix_t [2:0][2:0] px;
        coord_t          col;
        coord_t          row;
        logic            last;
    } window_t;

endpackage

// ===== hdl/prw_pixel_if.sv =====
// Input pixel channel: valid/ready handshake with one RGB word.
// Depends on prw_pkg.
interface prw_pixel_if
    import prw_pkg::*;
();
    logic  valid;
    logic  ready;
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

// ===== hdl/prw_edge_if.sv =====
// Result channel: valid/ready handshake with one edge magnitude word.
// Depends on prw_pkg.
interface prw_edge_if
    import prw_pkg::*;
();
    logic   valid;
    logic   ready;
    chan_t  edge_red;
    chan_t  edge_green;
    chan_t  edge_blue;
    coord_t center_column;
    coord_t center_row;
    logic   last_of_frame;

    modport source (output valid, edge_red, edge_green, edge_blue, center_column,
                    center_row, last_of_frame, input ready);
    modport sink   (input valid, edge_red, edge_green, edge_blue, center_column,
                    center_row, last_of_frame, output ready);
endinterface

// ===== hdl/prw_front.sv =====
// Front end: frame counters, configuration registers, line stores and window.
// Classifies each pixel word and pushes complete interior windows to the queue.
// Depends on prw_pkg and prw_pixel_if.
module prw_front
    import prw_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  dim_t                 cfg_data,
    prw_pixel_if.sink            pixel_stream,
    input  logic                 room,
    output logic                 push,
    output window_t              push_data
);

    localparam int unsigned DEPTH = (MAX_WIDTH < MAX_DIM) ? MAX_WIDTH : MAX_DIM;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam dim_t WIDTH_LIMIT  = DIM_W'(DEPTH);
    localparam dim_t HEIGHT_LIMIT = DIM_W'(MAX_DIM);
    localparam dim_t DIM_FLOOR    = DIM_W'(MIN_DIM);

    dim_t    width_reg;
    dim_t    height_reg;
    dim_t    eff_width;
    dim_t    eff_height;
    coord_t  col_reg;
    coord_t  row_reg;
    coord_t  col_next;
    coord_t  row_next;
    dim_t    col_ext;
    dim_t    row_ext;
    dim_t    col_inc;
    dim_t    row_inc;
    logic    accept;
    logic    emit;
    logic    last;
    logic    b_valid_reg;
    logic    b_emit_reg;
    logic    b_last_reg;
    coord_t  b_col_reg;
    coord_t  b_row_reg;
    pix_t    b_px_reg;
    logic [AW-1:0] b_addr_reg;
    logic [AW-1:0] rd_addr;
    pix_t    top_rd_reg;
    pix_t    mid_rd_reg;
    pix_t    pix_in;
    pix_t    win_reg [6];
    pix_t    upper_mem  [DEPTH];
    pix_t    middle_mem [DEPTH];

    // Clamp the programmed frame size
    always_comb
    begin
        eff_width = width_reg;
        if (width_reg < DIM_FLOOR)
        begin
            eff_width = DIM_FLOOR;
        end
        else if (width_reg > WIDTH_LIMIT)
        begin
            eff_width = WIDTH_LIMIT;
        end
        eff_height = height_reg;
        if (height_reg < DIM_FLOOR)
        begin
            eff_height = DIM_FLOOR;
        end
        else if (height_reg > HEIGHT_LIMIT)
        begin
            eff_height = HEIGHT_LIMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(512);
            height_reg <= DIM_W'(512);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pixel_stream.ready = room;
    assign accept  = pixel_stream.valid && room;
    assign pix_in  = '{blue: pixel_stream.blue_in, green: pixel_stream.green_in,
                       red: pixel_stream.red_in};
    // The column count stays below the clamped width, so it is the store address
    assign rd_addr = col_reg[AW-1:0];

    // Classify the incoming word and advance the raster position
    always_comb
    begin
        col_ext = {1'b0, col_reg};
        row_ext = {1'b0, row_reg};
        col_inc = col_ext + dim_t'(1);
        row_inc = row_ext + dim_t'(1);
        emit = (row_reg >= coord_t'(2)) && (col_reg >= coord_t'(2)) &&
               (col_ext < eff_width) && (row_ext < eff_height);
        last = (col_inc == eff_width) && (row_inc == eff_height);
        col_next = col_inc[CNT_W-1:0];
        row_next = row_reg;
        if (col_inc >= eff_width)
        begin
            col_next = '0;
            row_next = (row_inc >= eff_height) ? '0 : row_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            b_emit_reg  <= 1'b0;
        end
        else
        begin
            b_valid_reg <= accept;
            if (accept)
            begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                b_emit_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_col_reg  <= col_reg - coord_t'(1);
            b_row_reg  <= row_reg - coord_t'(1);
            b_last_reg <= last;
            b_px_reg   <= pix_in;
            b_addr_reg <= rd_addr;
        end
    end

    // Line stores: read on accept, write back in the next cycle at a different address
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_rd_reg <= upper_mem[rd_addr];
            mid_rd_reg <= middle_mem[rd_addr];
        end
        if (b_valid_reg)
        begin
            upper_mem[b_addr_reg]  <= mid_rd_reg;
            middle_mem[b_addr_reg] <= b_px_reg;
        end
    end

    // Shift the window by one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (b_valid_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_rd_reg;
            win_reg[4] <= mid_rd_reg;
            win_reg[5] <= b_px_reg;
        end
    end

    assign push = b_valid_reg && b_emit_reg;

    always_comb
    begin
        push_data.px[0][0] = win_reg[0];
        push_data.px[0][1] = win_reg[1];
        push_data.px[0][2] = win_reg[2];
        push_data.px[1][0] = win_reg[3];
        push_data.px[1][1] = win_reg[4];
        push_data.px[1][2] = win_reg[5];
        push_data.px[2][0] = top_rd_reg;
        push_data.px[2][1] = mid_rd_reg;
        push_data.px[2][2] = b_px_reg;
        push_data.col      = b_col_reg;
        push_data.row      = b_row_reg;
        push_data.last     = b_last_reg;
    end

    a_accept_reaches_store: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> b_valid_reg)
        else $error("accepted word did not reach the store stage");

    a_push_is_interior: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (b_col_reg != '0) && (b_row_reg != '0))
        else $error("window pushed for a border pixel");

endmodule

// ===== hdl/prw_queue.sv =====
// Short window queue between front and back ends.
// Reports room for a new input word, counting a push still in flight.
// Depends on prw_pkg.
module prw_queue
    import prw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  window_t push_data,
    input  logic    pop,
    output logic    head_valid,
    output window_t head,
    output logic    room
);

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    window_t        mem [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW:0]    pending;

    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign pending    = {1'b0, count_reg} + (CW + 1)'(push);
    assign room       = pending < (CW + 1)'(QUEUE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (count_reg != CW'(QUEUE_DEPTH)))
        else $error("window queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("window queue read while empty");

endmodule

// ===== hdl/prw_back.sv =====
// Back end: Prewitt responses per channel, saturated magnitude, output register.
// Depends on prw_pkg and prw_edge_if.
module prw_back
    import prw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  window_t   head,
    output logic      pop,
    prw_edge_if.source edge_stream
);

    logic   out_valid_reg;
    chan_t  red_reg;
    chan_t  green_reg;
    chan_t  blue_reg;
    coord_t col_reg;
    coord_t row_reg;
    logic   last_reg;
    chan_t  mag [3];

    function automatic chan_t prw_magnitude(input logic [2:0][2:0][CHAN_W-1:0] v);
        logic [9:0]         top;
        logic [9:0]         bot;
        logic [9:0]         lft;
        logic [9:0]         rgt;
        logic signed [10:0] gy;
        logic signed [10:0] gx;
        logic [9:0]         ay;
        logic [9:0]         ax;
        logic [10:0]        s;
        top = {2'b0, v[0][0]} + {2'b0, v[1][0]} + {2'b0, v[2][0]};
        bot = {2'b0, v[0][2]} + {2'b0, v[1][2]} + {2'b0, v[2][2]};
        lft = {2'b0, v[0][0]} + {2'b0, v[0][1]} + {2'b0, v[0][2]};
        rgt = {2'b0, v[2][0]} + {2'b0, v[2][1]} + {2'b0, v[2][2]};
        gy  = $signed({1'b0, top}) - $signed({1'b0, bot});
        gx  = $signed({1'b0, lft}) - $signed({1'b0, rgt});
        ay  = gy[10] ? 10'(-gy) : gy[9:0];
        ax  = gx[10] ? 10'(-gx) : gx[9:0];
        s   = {1'b0, ay} + {1'b0, ax};
        return (s > 11'd255) ? 8'hFF : s[7:0];
    endfunction

    always_comb
    begin
        logic [2:0][2:0][CHAN_W-1:0] v;
        for (int k = 0; k < 3; k++)
        begin
            for (int x = 0; x < 3; x++)
            begin
                for (int y = 0; y < 3; y++)
                begin
                    v[x][y] = head.px[x][y][CHAN_W*k +: CHAN_W];
                end
            end
            mag[k] = prw_magnitude(v);
        end
    end

    // Take the head whenever the output register is empty or being drained
    assign pop = head_valid && (!out_valid_reg || edge_stream.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || edge_stream.ready)
        begin
            out_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            red_reg   <= mag[0];
            green_reg <= mag[1];
            blue_reg  <= mag[2];
            col_reg   <= head.col;
            row_reg   <= head.row;
            last_reg  <= head.last;
        end
    end

    assign edge_stream.valid         = out_valid_reg;
    assign edge_stream.edge_red      = red_reg;
    assign edge_stream.edge_green    = green_reg;
    assign edge_stream.edge_blue     = blue_reg;
    assign edge_stream.center_column = col_reg;
    assign edge_stream.center_row    = row_reg;
    assign edge_stream.last_of_frame = last_reg;

endmodule

// ===== hdl/prewitt_edge_magnitude_rgb_core.sv =====
// 3x3 Prewitt edge magnitude on a raster RGB pixel stream.
// Use: drive pixel_stream with RGB words in raster order, one frame after another;
//   read edge_stream for one word per interior pixel (border pixels give none).
// Configuration: write image_width (index 0) and image_height (index 1) through
//   cfg_we / cfg_index / cfg_data while the block is idle; values are clamped to
//   [3, min(2048, MAX_WIDTH)] columns and [3, 2048] rows.
// Throughput: one pixel word per clock while the queue has room. Each word
//   costs a read and a store-stage write per line store, at distinct addresses.
// Path: the pixel completing a window passes the front store stage, the queue
//   and the output register before its result is valid on edge_stream.
// Stall: edge_stream.ready low holds the output register; the window queue
//   keeps absorbing words, and pixel_stream.ready drops once the queue cannot
//   take another word plus the one in flight.
// Reset: counters return to the frame start, the window clears and the size
//   registers go back to 512 x 512. Line stores are not cleared; the first two
//   rows of a frame fill them before any result uses them.
// last_of_frame marks the result for column width-2, row height-2.
// Depends on prw_pkg, prw_pixel_if, prw_edge_if, prw_front, prw_queue, prw_back.
module prewitt_edge_magnitude_rgb_core
    import prw_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    prw_pixel_if.sink            pixel_stream,
    prw_edge_if.source           edge_stream
);

    logic    room;
    logic    push;
    window_t push_data;
    logic    pop;
    logic    head_valid;
    window_t head;

    // Classify words, keep rows and window, push interior windows
    prw_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_stream (pixel_stream),
        .room         (room),
        .push         (push),
        .push_data    (push_data)
    );

    // Decouple the stream side from the result side
    prw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .room       (room)
    );

    // Compute magnitudes and hold the result word
    prw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .edge_stream (edge_stream)
    );

endmodule
